// ===== rtl/core/crsc_pkg.sv =====
// ----------------------------------------------------------------------------
// crsc_pkg
// Shared types, codes and saturation helpers for the complex RPN calculator.
// ----------------------------------------------------------------------------
package crsc_pkg;

  localparam int unsigned StackDepthDef   = 16;
  localparam int unsigned FractionBitsDef = 16;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POP  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_UNDER   = 2'd1,
    STS_OVER    = 2'd2,
    STS_DIVZERO = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ALU,
    ST_WB
  } top_state_e;

  typedef enum logic [2:0] {
    AL_IDLE,
    AL_PROD,
    AL_SUM,
    AL_LOAD,
    AL_DIV,
    AL_RND,
    AL_FIN
  } alu_state_e;

  typedef struct packed {
    logic signed [31:0] im;
    logic signed [31:0] re;
  } cval_t;

  typedef struct packed {
    logic  done;
    logic  divzero;
    cval_t val;
  } alu_res_t;

  function automatic logic signed [31:0] sat_sm(input logic neg, input logic [64:0] mag);
    logic signed [31:0] r;
    if (!neg) begin
      r = (mag > 65'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[31:0];
    end else if (mag >= 65'h0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = -mag[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
    logic signed [31:0] r;
    if (s > 33'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (s < -33'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/crsc_ram.sv =====
// ----------------------------------------------------------------------------
// crsc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module crsc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/crsc_alu.sv =====
// ----------------------------------------------------------------------------
// crsc_alu
// Multi-cycle complex ALU: one shared 32x32 multiplier, two serial dividers.
// ----------------------------------------------------------------------------
module crsc_alu import crsc_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FractionBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  op_e      op_i,
  input  cval_t    a_i,
  input  cval_t    b_i,
  output alu_res_t res_o
);

  localparam int unsigned Sh = 33 - FRACTION_BITS;

  alu_state_e state_q, state_d;
  op_e        op_q;
  cval_t      a_q, b_q;
  logic [2:0] step_q;
  logic [5:0] cnt_q;
  logic signed [63:0] p_q [6];
  logic        neg_q [2];
  logic [63:0] mag_q [2];
  logic [63:0] den_q;
  logic [63:0] rem_q [2];
  logic [32:0] quo_q [2];
  logic        ovf_q [2];
  logic        dz_q;
  cval_t       res_q;

  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic [2:0]         last_step;
  logic signed [64:0] s [2];
  logic [32:0] nlow [2];
  logic [5:0]  bidx;
  logic [64:0] r2 [2];
  logic [63:0] rem_nx [2];
  logic [32:0] quo_nx [2];
  logic [64:0] mq [2];
  logic [64:0] dq [2];
  logic [64:0] magx [2];
  logic [63:0] r0 [2];

  always_comb begin
    case (step_q)
      3'd0:    begin ma = a_q.re; mb = b_q.re; end
      3'd1:    begin ma = a_q.im; mb = b_q.im; end
      3'd2:    begin ma = a_q.re; mb = b_q.im; end
      3'd3:    begin ma = a_q.im; mb = b_q.re; end
      3'd4:    begin ma = b_q.re; mb = b_q.re; end
      default: begin ma = b_q.im; mb = b_q.im; end
    endcase
    prod = ma * mb;
    last_step = (op_q == OP_MUL) ? 3'd3 : 3'd5;
  end

  always_comb begin
    if (op_q == OP_MUL) begin
      s[0] = 65'(p_q[0]) - 65'(p_q[1]);
      s[1] = 65'(p_q[2]) + 65'(p_q[3]);
    end else begin
      s[0] = 65'(p_q[0]) + 65'(p_q[1]);
      s[1] = 65'(p_q[3]) - 65'(p_q[2]);
    end
    bidx = 6'd32 - cnt_q;
    for (int l = 0; l < 2; l++) begin
      nlow[l]   = 33'(mag_q[l] << FRACTION_BITS);
      r2[l]     = {rem_q[l], nlow[l][bidx]};
      if (r2[l] >= {1'b0, den_q}) begin
        rem_nx[l] = 64'(r2[l] - {1'b0, den_q});
        quo_nx[l] = {quo_q[l][31:0], 1'b1};
      end else begin
        rem_nx[l] = r2[l][63:0];
        quo_nx[l] = {quo_q[l][31:0], 1'b0};
      end
      magx[l] = {mag_q[l], 1'b0};
      mq[l]   = 65'(mag_q[l] >> FRACTION_BITS) + 65'(magx[l][FRACTION_BITS]);
      dq[l]   = ovf_q[l] ? '1
              : 65'(quo_q[l]) + 65'({rem_q[l], 1'b0} >= {1'b0, den_q});
      r0[l]   = mag_q[l] >> Sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      AL_IDLE: begin
        if (start_i) begin
          state_d = (op_i == OP_ADD || op_i == OP_SUB) ? AL_FIN : AL_PROD;
        end
      end
      AL_PROD: if (step_q == last_step) state_d = AL_SUM;
      AL_SUM:  state_d = AL_LOAD;
      AL_LOAD: state_d = (op_q == OP_MUL || den_q == '0) ? AL_FIN : AL_DIV;
      AL_DIV:  if (cnt_q == 6'd32) state_d = AL_RND;
      AL_RND:  state_d = AL_FIN;
      AL_FIN:  state_d = AL_IDLE;
      default: state_d = AL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      AL_IDLE: begin
        if (start_i) begin
          op_q   <= op_i;
          a_q    <= a_i;
          b_q    <= b_i;
          step_q <= '0;
          dz_q   <= 1'b0;
          if (op_i == OP_ADD) begin
            res_q.re <= sat33(33'(a_i.re) + 33'(b_i.re));
            res_q.im <= sat33(33'(a_i.im) + 33'(b_i.im));
          end else begin
            res_q.re <= sat33(33'(a_i.re) - 33'(b_i.re));
            res_q.im <= sat33(33'(a_i.im) - 33'(b_i.im));
          end
        end
      end
      AL_PROD: begin
        p_q[step_q] <= prod;
        step_q      <= step_q + 3'd1;
      end
      AL_SUM: begin
        for (int l = 0; l < 2; l++) begin
          neg_q[l] <= s[l][64];
          mag_q[l] <= s[l][64] ? 64'(-s[l]) : s[l][63:0];
        end
        den_q <= 64'(p_q[4]) + 64'(p_q[5]);
      end
      AL_LOAD: begin
        cnt_q <= '0;
        if (op_q == OP_MUL) begin
          res_q.re <= sat_sm(neg_q[0], mq[0]);
          res_q.im <= sat_sm(neg_q[1], mq[1]);
        end else if (den_q == '0) begin
          dz_q  <= 1'b1;
          res_q <= '0;
        end else begin
          for (int l = 0; l < 2; l++) begin
            rem_q[l] <= r0[l];
            ovf_q[l] <= r0[l] >= den_q;
            quo_q[l] <= '0;
          end
        end
      end
      AL_DIV: begin
        cnt_q <= cnt_q + 6'd1;
        for (int l = 0; l < 2; l++) begin
          rem_q[l] <= rem_nx[l];
          quo_q[l] <= quo_nx[l];
        end
      end
      AL_RND: begin
        res_q.re <= sat_sm(neg_q[0], dq[0]);
        res_q.im <= sat_sm(neg_q[1], dq[1]);
      end
      default: ;
    endcase
  end

  assign res_o.done    = (state_q == AL_FIN);
  assign res_o.divzero = dz_q;
  assign res_o.val     = res_q;

endmodule

// ===== rtl/core/complex_rpn_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// complex_rpn_stack_calculator
// Reverse-Polish calculator on complex Q16.16 values with a RAM-based stack.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the operation (push, add, subtract, multiply,
// divide, pop), tdata the complex operand used by push. Every input transfer
// yields exactly one output transfer: tdata holds the new top of stack (or
// the popped value) and the depth after the item, tuser the status.
// Push, pop and unused codes load the output register directly; a pop that
// leaves entries behind then reloads the top from the stack RAM. Add,
// subtract, multiply (four products through one shared 32x32 multiplier)
// and divide (six products, then 33 quotient steps of two parallel
// restoring dividers) go through stack read, ALU and write-back.
// Only one item is in work at a time; a new item is taken once the previous
// result has left the output register or leaves it in the same cycle.
// Reset empties the stack; the RAM holds no reset value. A stalled receiver
// holds the result in the output register and blocks new input transfers.
// ----------------------------------------------------------------------------
module complex_rpn_stack_calculator import crsc_pkg::*; #(
  parameter int unsigned STACK_DEPTH   = StackDepthDef,
  parameter int unsigned FRACTION_BITS = FractionBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // operand_real, operand_imag
  input  logic [2:0]  s_axis_tuser_i,  // operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,  // result_real, result_imag, depth, zero pad
  output logic [1:0]  m_axis_tuser_o   // status
);

  localparam int unsigned Aw = $clog2(STACK_DEPTH);
  localparam int unsigned Sw = $clog2(STACK_DEPTH + 1);

  top_state_e state_q, state_d;
  logic [Sw-1:0] sp_q, sp_d;
  op_e   op_q, op_d;
  cval_t top_q, top_d;
  logic  out_valid_q, out_valid_d;
  cval_t out_val_q, out_val_d;
  status_e out_sts_q, out_sts_d;
  logic [4:0] out_dep_q, out_dep_d;

  logic    accept, out_free, out_load;
  logic    we, re;
  logic [Aw-1:0] waddr, raddr;
  cval_t   wdata, rdata, in_val, shown;
  op_e     in_op;
  logic    alu_start;
  alu_res_t alu_res;

  crsc_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  crsc_alu #(.FRACTION_BITS(FRACTION_BITS)) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .op_i    (op_q),
    .a_i     (rdata),
    .b_i     (top_q),
    .res_o   (alu_res)
  );

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op           = op_e'(s_axis_tuser_i);
  assign in_val          = s_axis_tdata_i;
  assign shown           = (sp_q == '0) ? '0 : top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    top_q <= top_d;
    if (out_load) begin
      out_val_q <= out_val_d;
      out_sts_q <= out_sts_d;
      out_dep_q <= out_dep_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    op_d      = op_q;
    top_d     = top_q;
    out_load  = 1'b0;
    out_val_d = shown;
    out_sts_d = STS_OK;
    we        = 1'b0;
    waddr     = Aw'(sp_q);
    wdata     = in_val;
    re        = 1'b0;
    raddr     = Aw'(sp_q - Sw'(2));
    alu_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (in_op)
            OP_PUSH: begin
              if (sp_q >= Sw'(STACK_DEPTH)) begin
                out_sts_d = STS_OVER;
              end else begin
                we        = 1'b1;
                top_d     = in_val;
                sp_d      = sp_q + Sw'(1);
                out_val_d = in_val;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (sp_q < Sw'(2)) begin
                out_sts_d = STS_UNDER;
              end else begin
                out_load = 1'b0;
                re       = 1'b1;
                op_d     = in_op;
                state_d  = ST_READ;
              end
            end
            OP_POP: begin
              if (sp_q == '0) begin
                out_sts_d = STS_UNDER;
              end else begin
                sp_d      = sp_q - Sw'(1);
                out_val_d = top_q;
                op_d      = in_op;
                if (sp_q >= Sw'(2)) begin
                  re      = 1'b1;
                  state_d = ST_READ;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (op_q == OP_POP) begin
          top_d   = rdata;
          state_d = ST_IDLE;
        end else begin
          alu_start = 1'b1;
          state_d   = ST_ALU;
        end
      end
      ST_ALU: begin
        if (alu_res.done) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (out_free) begin
          we        = 1'b1;
          waddr     = Aw'(sp_q - Sw'(2));
          wdata     = alu_res.val;
          top_d     = alu_res.val;
          sp_d      = sp_q - Sw'(1);
          out_load  = 1'b1;
          out_val_d = alu_res.val;
          out_sts_d = alu_res.divzero ? STS_DIVZERO : STS_OK;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_dep_d   = 5'(sp_d);
    out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_dep_q, out_val_q.im, out_val_q.re};
  assign m_axis_tuser_o  = out_sts_q;

endmodule

// ===== rtl/core/crsc_chk.sv =====
// ----------------------------------------------------------------------------
// crsc_chk
// Port-level checks for the complex RPN calculator, bound to the top level.
// ----------------------------------------------------------------------------
module crsc_chk import crsc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STS_OVER |->
      m_axis_tdata_o[68:64] == 5'(STACK_DEPTH))
    else $error("overflow reported below full depth");

  a_divzero_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STS_DIVZERO |->
      m_axis_tdata_o[63:0] == 64'd0 && m_axis_tdata_o[68:64] != 5'd0)
    else $error("divide by zero must report zero");

  a_under_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[68:64] == 5'd0 && STACK_DEPTH < 32 |->
      m_axis_tdata_o[63:0] == 64'd0 || m_axis_tuser_o == STS_OK)
    else $error("empty stack reports nonzero value");

endmodule

bind complex_rpn_stack_calculator crsc_chk #(.STACK_DEPTH(STACK_DEPTH)) u_crsc_chk (.*);
